>>> hdl/gbe_pkg.sv
`timescale 1ns / 1ps

package gbe_pkg;

  localparam int CAPACITY = 1024;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int PTR_W    = ADDR_W + 1;
  localparam int AMT_W    = 12;
  // wide enough for a signed offset against the cursor and for a read position
  localparam int OFF_W    = ((AMT_W > PTR_W) ? AMT_W : PTR_W) + 1;

  localparam logic [2:0] OP_MOVE   = 3'd0;
  localparam logic [2:0] OP_SET    = 3'd1;
  localparam logic [2:0] OP_INSERT = 3'd2;
  localparam logic [2:0] OP_DELETE = 3'd3;
  localparam logic [2:0] OP_READ   = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic [2:0]              opcode;
    logic signed [AMT_W-1:0] amount;
    logic [7:0]              value;
    logic [9:0]              position;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  read_value;
    logic [10:0] cursor;
    logic [10:0] length;
  } rsp_t;

  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic [ADDR_W-1:0] rd_addr;
  } mem_req_t;

endpackage

>>> hdl/gbe_store.sv
`timescale 1ns / 1ps

module gbe_store (
  input  logic             clk,
  input  gbe_pkg::mem_req_t req,
  output logic [7:0]       rd_data
);

  logic [7:0] mem [gbe_pkg::CAPACITY];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    rd_data <= mem[req.rd_addr];
  end

endmodule

>>> hdl/gap_buffer_editor_core.sv
`timescale 1ns / 1ps

// Gap buffer text editor, 1024-byte store in one single-port-write RAM.
// Command channel: cmd is taken at a rising edge with start high and busy low.
// Result channel: rsp is valid for exactly one cycle while done is high; the
// receiver must take it then, there is no back-pressure.
// Every command gives one result word.
// From accept to done:
//   insert, delete, unused opcodes, failed read, zero-length move: done in
//     the next cycle, busy stays low so a new command may follow straight away;
//   read inside the text: through S_RDWAIT, after one RAM read;
//   move / set cursor over n bytes: through S_COPY, one byte across the gap
//     per cycle, read and write-back overlapped in the RAM.
// busy is high while a read or a copy is in flight.
// Reset (rst, synchronous) empties the text: cursor 0, length 0. The RAM is
// not cleared; bytes outside the text are never returned.

module gap_buffer_editor_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  gbe_pkg::cmd_t cmd,
  output logic          busy,
  output logic          done,
  output gbe_pkg::rsp_t rsp
);

  localparam int ADDR_W = gbe_pkg::ADDR_W;
  localparam int PTR_W  = gbe_pkg::PTR_W;
  localparam int OFF_W  = gbe_pkg::OFF_W;
  localparam logic [PTR_W-1:0] CAP = PTR_W'(gbe_pkg::CAPACITY);

  typedef enum logic [1:0] {S_IDLE, S_COPY, S_RDWAIT} state_t;

  state_t            state;
  logic [PTR_W-1:0]  gap_begin;
  logic [PTR_W-1:0]  gap_finish;
  logic [PTR_W-1:0]  rd_cnt;
  logic [PTR_W-1:0]  mv_cnt;
  logic              mv_left;
  logic              wr_pend;
  logic [ADDR_W-1:0] rptr;
  logic [ADDR_W-1:0] wptr;

  gbe_pkg::mem_req_t mem_req;
  logic [7:0]        rd_data;

  logic                    accept;
  logic signed [OFF_W-1:0] amt_ext;
  logic signed [OFF_W-1:0] gb_s;
  logic signed [OFF_W-1:0] offset;
  logic                    off_left;
  logic [OFF_W-1:0]        off_mag;
  logic [PTR_W-1:0]        tail;
  logic [PTR_W-1:0]        mv_lim;
  logic [PTR_W-1:0]        mv_n;
  logic                    del_neg;
  logic [OFF_W-1:0]        del_mag;
  logic [PTR_W-1:0]        del_lim;
  logic [PTR_W-1:0]        del_n;
  logic                    full;
  logic [PTR_W-1:0]        len;
  logic [OFF_W-1:0]        pos_w;
  logic [OFF_W-1:0]        idx_w;
  logic                    in_range;

  function automatic gbe_pkg::rsp_t make_rsp(input logic [1:0] st, input logic [7:0] rv,
                                             input logic [PTR_W-1:0] gb,
                                             input logic [PTR_W-1:0] gf);
    gbe_pkg::rsp_t r;
    logic [PTR_W-1:0] l;
    l = gb + (CAP - gf);
    r.status     = st;
    r.read_value = rv;
    r.cursor     = 11'(gb);
    r.length     = 11'(l);
    return r;
  endfunction

  assign accept = start && !busy;
  assign busy   = (state != S_IDLE);

  // move / set cursor: signed offset, clamped to the text on that side
  assign amt_ext  = OFF_W'(cmd.amount);
  assign gb_s     = $signed(OFF_W'(gap_begin));
  assign offset   = (cmd.opcode == gbe_pkg::OP_SET) ? (amt_ext - gb_s) : amt_ext;
  assign off_left = offset[OFF_W-1];
  assign off_mag  = off_left ? OFF_W'(-offset) : OFF_W'(offset);
  assign tail     = CAP - gap_finish;
  assign mv_lim   = off_left ? gap_begin : tail;
  assign mv_n     = (off_mag > OFF_W'(mv_lim)) ? mv_lim : PTR_W'(off_mag);

  // delete: negative eats after the cursor, positive before it
  assign del_neg = cmd.amount[gbe_pkg::AMT_W-1];
  assign del_mag = del_neg ? OFF_W'(-amt_ext) : OFF_W'(amt_ext);
  assign del_lim = del_neg ? tail : gap_begin;
  assign del_n   = (del_mag > OFF_W'(del_lim)) ? del_lim : PTR_W'(del_mag);

  assign full = (gap_finish == gap_begin);

  assign len      = gap_begin + tail;
  assign pos_w    = OFF_W'(cmd.position);
  assign in_range = pos_w < OFF_W'(len);
  assign idx_w    = (pos_w < OFF_W'(gap_begin)) ? pos_w
                                                : pos_w + OFF_W'(gap_finish - gap_begin);

  // RAM port: copy owns it in S_COPY, else an insert or read being accepted
  always_comb begin
    if (state == S_COPY) begin
      mem_req.wr_en   = wr_pend;
      mem_req.wr_addr = wptr;
      mem_req.wr_data = rd_data;
      mem_req.rd_addr = rptr;
    end else begin
      mem_req.wr_en   = accept && (cmd.opcode == gbe_pkg::OP_INSERT) && !full;
      mem_req.wr_addr = gap_begin[ADDR_W-1:0];
      mem_req.wr_data = cmd.value;
      mem_req.rd_addr = idx_w[ADDR_W-1:0];
    end
  end

  gbe_store u_store (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      gap_begin  <= '0;
      gap_finish <= CAP;
      rd_cnt     <= '0;
      wr_pend    <= 1'b0;
      done       <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (cmd.opcode) inside
              gbe_pkg::OP_MOVE, gbe_pkg::OP_SET: begin
                if (mv_n == '0) begin
                  done <= 1'b1;
                  rsp  <= make_rsp(gbe_pkg::ST_OK, 8'd0, gap_begin, gap_finish);
                end else begin
                  state   <= S_COPY;
                  rd_cnt  <= mv_n;
                  mv_cnt  <= mv_n;
                  mv_left <= off_left;
                  wr_pend <= 1'b0;
                  if (off_left) begin
                    rptr <= ADDR_W'(gap_begin - PTR_W'(1));
                    wptr <= ADDR_W'(gap_finish - PTR_W'(1));
                  end else begin
                    rptr <= gap_finish[ADDR_W-1:0];
                    wptr <= gap_begin[ADDR_W-1:0];
                  end
                end
              end
              gbe_pkg::OP_INSERT: begin
                done <= 1'b1;
                if (full) begin
                  rsp <= make_rsp(gbe_pkg::ST_FULL, 8'd0, gap_begin, gap_finish);
                end else begin
                  gap_begin <= gap_begin + PTR_W'(1);
                  rsp <= make_rsp(gbe_pkg::ST_OK, 8'd0, gap_begin + PTR_W'(1), gap_finish);
                end
              end
              gbe_pkg::OP_DELETE: begin
                done <= 1'b1;
                if (del_neg) begin
                  gap_finish <= gap_finish + del_n;
                  rsp <= make_rsp(gbe_pkg::ST_OK, 8'd0, gap_begin, gap_finish + del_n);
                end else begin
                  gap_begin <= gap_begin - del_n;
                  rsp <= make_rsp(gbe_pkg::ST_OK, 8'd0, gap_begin - del_n, gap_finish);
                end
              end
              gbe_pkg::OP_READ: begin
                if (in_range) begin
                  state <= S_RDWAIT;
                end else begin
                  done <= 1'b1;
                  rsp  <= make_rsp(gbe_pkg::ST_RANGE, 8'd0, gap_begin, gap_finish);
                end
              end
              default: begin
                done <= 1'b1;
                rsp  <= make_rsp(gbe_pkg::ST_OK, 8'd0, gap_begin, gap_finish);
              end
            endcase
          end
        end
        S_COPY: begin
          // each byte is written back in the cycle after it is read; left moves run downwards
          if (rd_cnt != '0) begin
            rptr   <= mv_left ? rptr - ADDR_W'(1) : rptr + ADDR_W'(1);
            rd_cnt <= rd_cnt - PTR_W'(1);
          end
          wr_pend <= (rd_cnt != '0);
          if (wr_pend) begin
            wptr <= mv_left ? wptr - ADDR_W'(1) : wptr + ADDR_W'(1);
          end
          if ((rd_cnt == '0) && wr_pend) begin
            state <= S_IDLE;
            done  <= 1'b1;
            if (mv_left) begin
              gap_begin  <= gap_begin - mv_cnt;
              gap_finish <= gap_finish - mv_cnt;
              rsp <= make_rsp(gbe_pkg::ST_OK, 8'd0, gap_begin - mv_cnt, gap_finish - mv_cnt);
            end else begin
              gap_begin  <= gap_begin + mv_cnt;
              gap_finish <= gap_finish + mv_cnt;
              rsp <= make_rsp(gbe_pkg::ST_OK, 8'd0, gap_begin + mv_cnt, gap_finish + mv_cnt);
            end
          end
        end
        S_RDWAIT: begin
          state <= S_IDLE;
          done  <= 1'b1;
          rsp   <= make_rsp(gbe_pkg::ST_OK, rd_data, gap_begin, gap_finish);
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  a_gap_order: assert property (@(posedge clk) disable iff (rst)
    gap_begin <= gap_finish && gap_finish <= CAP)
    else $error("gap ends out of order");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result word while still busy");

  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    accept |=> (done || busy))
    else $error("accepted command left no trace");

  a_full_drop: assert property (@(posedge clk) disable iff (rst)
    accept && cmd.opcode == gbe_pkg::OP_INSERT && full
    |=> done && rsp.status == gbe_pkg::ST_FULL && $stable(gap_begin))
    else $error("insert into full buffer not dropped");
`endif

endmodule

>>> test/tb_gap_buffer_editor_core.sv
`timescale 1ns / 1ps

module tb_gap_buffer_editor_core;

  // opcodes with no defined action
  localparam logic [2:0] OP_SPARE_A = 3'd5;
  localparam logic [2:0] OP_SPARE_B = 3'd6;
  localparam logic [2:0] OP_SPARE_C = 3'd7;

  logic clk;
  logic rst = 1'b1;
  logic start = 1'b0;
  gbe_pkg::cmd_t cmd = '0;
  logic busy;
  logic done;
  gbe_pkg::rsp_t rsp;

  gap_buffer_editor_core dut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done),
    .rsp   (rsp)
  );

  // shadow of the editor: store and the two ends of the gap
  logic [7:0] text_mem [gbe_pkg::CAPACITY];
  int gap_lo = 0;
  int gap_hi = gbe_pkg::CAPACITY;

  gbe_pkg::rsp_t edit_results_due [$];
  int errors = 0;
  int burst_left = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #200_000_000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic int text_len();
    return gap_lo + gbe_pkg::CAPACITY - gap_hi;
  endfunction

  // carry bytes across the gap; copy direction keeps overlapping ranges intact
  function automatic void shift_cursor(int off);
    int n;
    int i;
    if (off <= 0) begin
      n = -off;
      if (n > gap_lo) n = gap_lo;
      if (n == 0) return;
      gap_lo -= n;
      gap_hi -= n;
      for (i = n - 1; i >= 0; i--) text_mem[gap_hi + i] = text_mem[gap_lo + i];
    end else begin
      n = off;
      if (n > gbe_pkg::CAPACITY - gap_hi) n = gbe_pkg::CAPACITY - gap_hi;
      if (n == 0) return;
      for (i = 0; i < n; i++) text_mem[gap_lo + i] = text_mem[gap_hi + i];
      gap_lo += n;
      gap_hi += n;
    end
  endfunction

  function automatic gbe_pkg::rsp_t apply_edit(gbe_pkg::cmd_t c);
    gbe_pkg::rsp_t r;
    int amt;
    int n;
    int pos;
    r = '0;
    amt = int'($signed(c.amount));
    pos = int'(c.position);
    case (c.opcode)
      gbe_pkg::OP_MOVE: shift_cursor(amt);
      gbe_pkg::OP_SET:  shift_cursor(amt - gap_lo);
      gbe_pkg::OP_INSERT: begin
        if (gap_hi > gap_lo) begin
          text_mem[gap_lo] = c.value;
          gap_lo++;
        end else begin
          r.status = gbe_pkg::ST_FULL;
        end
      end
      gbe_pkg::OP_DELETE: begin
        if (amt < 0) begin
          n = -amt;
          if (n > gbe_pkg::CAPACITY - gap_hi) n = gbe_pkg::CAPACITY - gap_hi;
          gap_hi += n;
        end else if (amt > 0) begin
          n = amt;
          if (n > gap_lo) n = gap_lo;
          gap_lo -= n;
        end
      end
      gbe_pkg::OP_READ: begin
        if (pos < text_len()) begin
          r.read_value = (pos < gap_lo) ? text_mem[pos] : text_mem[pos + gap_hi - gap_lo];
        end else begin
          r.status = gbe_pkg::ST_RANGE;
        end
      end
      default: ;
    endcase
    r.cursor = gap_lo[10:0];
    r.length = 11'(text_len());
    return r;
  endfunction

  function automatic gbe_pkg::cmd_t make_cmd(logic [2:0] op, int amt, int val, int pos);
    gbe_pkg::cmd_t c;
    c.opcode   = op;
    c.amount   = amt[11:0];
    c.value    = val[7:0];
    c.position = pos[9:0];
    return c;
  endfunction

  function automatic int any_amount();
    return int'($urandom_range(0, 4095)) - 2048;
  endfunction

  // one word per call; start stays high across a burst, drops for the gaps
  task automatic send_word(gbe_pkg::cmd_t c);
    int gap;
    start <= 1'b1;
    cmd   <= c;
    do @(posedge clk); while (busy);
    edit_results_due.push_back(apply_edit(c));
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 15);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (edit_results_due.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    gbe_pkg::rsp_t want;
    if (!rst && done) begin
      if (edit_results_due.size() == 0) begin
        $display("%0t: unexpected result word, expected none actual %h", $time, rsp);
        errors++;
      end else begin
        want = edit_results_due.pop_front();
        check_field("status", int'(want.status), int'(rsp.status));
        check_field("read_value", int'(want.read_value), int'(rsp.read_value));
        check_field("cursor", int'(want.cursor), int'(rsp.cursor));
        check_field("length", int'(want.length), int'(rsp.length));
      end
    end
  end

  task automatic test_empty_buffer();
    send_word(make_cmd(gbe_pkg::OP_READ, 0, 0, 0));
    send_word(make_cmd(gbe_pkg::OP_MOVE, -5, 0, 0));
    send_word(make_cmd(gbe_pkg::OP_MOVE, 5, 0, 0));
    send_word(make_cmd(gbe_pkg::OP_SET, 100, 0, 0));
    send_word(make_cmd(gbe_pkg::OP_DELETE, 3, 0, 0));
    send_word(make_cmd(gbe_pkg::OP_DELETE, -3, 0, 0));
    send_word(make_cmd(OP_SPARE_A, -2048, 255, 1023));
    drain();
  endtask

  task automatic test_basic_edit();
    send_word(make_cmd(gbe_pkg::OP_INSERT, 0, 'h00, 0));
    send_word(make_cmd(gbe_pkg::OP_INSERT, 0, 'hff, 0));
    send_word(make_cmd(gbe_pkg::OP_INSERT, 0, 'ha5, 0));
    send_word(make_cmd(gbe_pkg::OP_INSERT, 0, 'h5a, 0));
    send_word(make_cmd(gbe_pkg::OP_READ, 0, 0, 0));
    send_word(make_cmd(gbe_pkg::OP_READ, 0, 0, 3));
    send_word(make_cmd(gbe_pkg::OP_READ, 0, 0, 4));
    send_word(make_cmd(gbe_pkg::OP_READ, 0, 0, 1023));
    send_word(make_cmd(gbe_pkg::OP_MOVE, -2, 0, 0));
    send_word(make_cmd(gbe_pkg::OP_INSERT, 0, 'h3c, 0));
    send_word(make_cmd(gbe_pkg::OP_READ, 0, 0, 2));
    send_word(make_cmd(gbe_pkg::OP_MOVE, 0, 0, 0));
    send_word(make_cmd(gbe_pkg::OP_DELETE, 0, 0, 0));
    send_word(make_cmd(gbe_pkg::OP_MOVE, 2047, 0, 0));
    send_word(make_cmd(gbe_pkg::OP_MOVE, -2048, 0, 0));
    send_word(make_cmd(gbe_pkg::OP_SET, 2047, 0, 0));
    send_word(make_cmd(gbe_pkg::OP_SET, -1, 0, 0));
    send_word(make_cmd(gbe_pkg::OP_DELETE, -1, 0, 0));
    send_word(make_cmd(gbe_pkg::OP_SET, 2, 0, 0));
    send_word(make_cmd(gbe_pkg::OP_DELETE, 1, 0, 0));
    send_word(make_cmd(gbe_pkg::OP_READ, 0, 0, 1));
    send_word(make_cmd(OP_SPARE_B, 1, 1, 1));
    send_word(make_cmd(OP_SPARE_C, 0, 0, 0));
    send_word(make_cmd(gbe_pkg::OP_DELETE, -2048, 0, 0));
    send_word(make_cmd(gbe_pkg::OP_DELETE, 2047, 0, 0));
    drain();
  endtask

  // fill to capacity with the cursor wandering, then full-length moves
  task automatic test_full_buffer();
    int i;
    for (i = 0; gap_hi > gap_lo; i++) begin
      if (i % 128 == 127)
        send_word(make_cmd(gbe_pkg::OP_MOVE, -int'($urandom_range(0, 60)), 0, 0));
      send_word(make_cmd(gbe_pkg::OP_INSERT, 0, $urandom_range(0, 255), 0));
    end
    send_word(make_cmd(gbe_pkg::OP_INSERT, 0, 'h77, 0));
    send_word(make_cmd(gbe_pkg::OP_SET, 2047, 0, 0));
    send_word(make_cmd(gbe_pkg::OP_INSERT, 0, 'h88, 0));
    send_word(make_cmd(gbe_pkg::OP_READ, 0, 0, 0));
    send_word(make_cmd(gbe_pkg::OP_READ, 0, 0, 1023));
    send_word(make_cmd(gbe_pkg::OP_SET, 0, 0, 0));
    send_word(make_cmd(gbe_pkg::OP_READ, 0, 0, 511));
    send_word(make_cmd(gbe_pkg::OP_MOVE, 1024, 0, 0));
    send_word(make_cmd(gbe_pkg::OP_MOVE, -1024, 0, 0));
    send_word(make_cmd(gbe_pkg::OP_READ, 0, 0, 1023));
    send_word(make_cmd(gbe_pkg::OP_DELETE, -2048, 0, 0));
    send_word(make_cmd(gbe_pkg::OP_READ, 0, 0, 0));
    drain();
  endtask

  task automatic test_random_edits(int count);
    int k;
    int sel;
    int len;
    for (k = 0; k < count; k++) begin
      sel = $urandom_range(0, 99);
      len = text_len();
      if (sel < 5) begin
        send_word(make_cmd(3'($urandom_range(0, 7)), any_amount(), $urandom_range(0, 255),
                           $urandom_range(0, 1023)));
      end else if (sel < 40 && len < 600) begin
        send_word(make_cmd(gbe_pkg::OP_INSERT, any_amount(), $urandom_range(0, 255),
                           $urandom_range(0, 1023)));
      end else if (sel < 52) begin
        if ($urandom_range(0, 9) == 0)
          send_word(make_cmd(gbe_pkg::OP_MOVE, any_amount(), 0, 0));
        else
          send_word(make_cmd(gbe_pkg::OP_MOVE, int'($urandom_range(0, 40)) - 20, 0, 0));
      end else if (sel < 62) begin
        if ($urandom_range(0, 7) == 0)
          send_word(make_cmd(gbe_pkg::OP_SET, any_amount(), 0, 0));
        else
          send_word(make_cmd(gbe_pkg::OP_SET, $urandom_range(0, len), 0, 0));
      end else if (sel < 72 || sel < 40) begin
        if ($urandom_range(0, 15) == 0)
          send_word(make_cmd(gbe_pkg::OP_DELETE, any_amount(), 0, 0));
        else
          send_word(make_cmd(gbe_pkg::OP_DELETE, int'($urandom_range(0, 16)) - 8, 0, 0));
      end else if (sel < 97) begin
        if ($urandom_range(0, 7) == 0 || len == 0)
          send_word(make_cmd(gbe_pkg::OP_READ, 0, 0, $urandom_range(0, 1023)));
        else
          send_word(make_cmd(gbe_pkg::OP_READ, any_amount(), $urandom_range(0, 255),
                             $urandom_range(0, len)));
      end else begin
        send_word(make_cmd(3'($urandom_range(OP_SPARE_A, OP_SPARE_C)), any_amount(),
                           $urandom_range(0, 255), $urandom_range(0, 1023)));
      end
    end
    drain();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_buffer();
    test_basic_edit();
    test_full_buffer();
    test_random_edits(580);
    repeat (1030) @(posedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/gbe_pkg.sv
hdl/gbe_store.sv
hdl/gap_buffer_editor_core.sv
test/tb_gap_buffer_editor_core.sv
